@@ rtl/jdes_pkg.sv @@
// ----------------------------------------------------------------------------
// jdes_pkg
// Shared constants for the joystick deadzone, cubic expo and smoothing block.
// ----------------------------------------------------------------------------
package jdes_pkg;

  // Default sizes of the block
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF   = 16;

  // Width of one output position field
  localparam int POS_W = 8;

  // Configuration register indexes
  localparam int                 CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD   = 1'b1;

  // Reset value of the dead band half width
  localparam int DEAD_RESET = 200;

  // Arithmetic constants of the shaping curve and the smoother
  localparam int LIN_FULL   = 100;
  localparam int CUBE_SCALE = 10000;
  localparam int SMOOTH_DIV = 5;

endpackage

@@ rtl/jdes_div.sv @@
// ----------------------------------------------------------------------------
// jdes_div
// Shared restoring divider, unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jdes_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_next;
  logic             fits;

  // The numerator shifts out of the top of quo while quotient bits shift in.
  always_comb begin
    rem_sh   = {rem, quo[NUM_W-1]};
    fits     = rem_sh >= {1'b0, den_r};
    rem_next = fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == '0);
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(NUM_W - 1);
        rem   <= '0;
        quo   <= num;
        den_r <= den;
      end else if (busy) begin
        rem <= rem_next[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], fits};
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/jdes_seq.sv @@
// ----------------------------------------------------------------------------
// jdes_seq
// Sequencer: shapes and smooths the two axes in turn, sharing one divider.
// ----------------------------------------------------------------------------
module jdes_seq import jdes_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SAMPLE_BITS-1:0] center,
  input  logic [SAMPLE_BITS-1:0] dead,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] x_in,
  input  logic [SAMPLE_BITS-1:0] y_in,
  output logic                   res_valid,
  input  logic                   res_take,
  output logic signed [POS_W-1:0] x_pos,
  output logic signed [POS_W-1:0] y_pos
);

  localparam int S         = SAMPLE_BITS;
  localparam int F         = FRAC_BITS;
  localparam int ST_W      = F + 8;
  localparam int SUM_W     = F + 11;
  localparam int MAG_W     = F + 9;
  localparam int LIN_NUM_W = S + 7;
  localparam int CUBE_W    = 21;
  localparam int SQ_W      = 14;
  localparam int NUM_W     = LIN_NUM_W;
  localparam int DEN_W     = S;
  localparam logic [S:0] MAX_CODE = {1'b0, {S{1'b1}}};

  // The cube is divided as (cube/16)/625; the second step multiplies by the
  // rounded-up reciprocal, which is exact for every value below 2^16.
  localparam int CUBE_PRE    = 4;
  localparam int CUBE_SH     = 26;
  localparam int CUBE_DIV    = CUBE_SCALE >> CUBE_PRE;
  localparam int CUBE_RCP_W  = 17;
  localparam int CUBE_PROD_W = CUBE_W - CUBE_PRE + CUBE_RCP_W;
  localparam logic [CUBE_RCP_W-1:0] CUBE_RCP =
    CUBE_RCP_W'(((1 << CUBE_SH) + CUBE_DIV - 1) / CUBE_DIV);

  // Division by five multiplies by (2^k + 1)/5, where k is at least MAG_W and
  // 2^k is one short of a multiple of five, so every sum divides exactly.
  localparam int RCP5_SH   = MAG_W + ((6 - (MAG_W % 4)) % 4);
  localparam int RCP5_W    = RCP5_SH - 2;
  localparam int SM_PROD_W = MAG_W + RCP5_W;
  localparam logic [RCP5_W-1:0] RCP5 =
    RCP5_W'(((longint'(1) << RCP5_SH) + 1) / SMOOTH_DIV);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_SHAPE   = 9'b000000010,
    ST_LINDIV  = 9'b000000100,
    ST_MAG     = 9'b000001000,
    ST_CUBE    = 9'b000010000,
    ST_CUBEDIV = 9'b000100000,
    ST_SMOOTH  = 9'b001000000,
    ST_SMDIV   = 9'b010000000,
    ST_DONE    = 9'b100000000
  } state_t;

  state_t state;
  logic   axis;

  logic [S-1:0] raw_x;
  logic [S-1:0] raw_y;
  logic signed [ST_W-1:0] x_filt;
  logic signed [ST_W-1:0] y_filt;

  logic signed [7:0] lin;
  logic              lin_low;
  logic [6:0]        mag;
  logic              neg;
  logic [SQ_W-1:0]   sq;
  logic signed [7:0] tgt;
  logic              sneg;

  // shaping terms
  logic [S-1:0]     raw;
  logic [S:0]       ce;
  logic [S:0]       diff;
  logic [S:0]       dist_w;
  logic             in_band;
  logic             upper;
  logic             lower;
  logic [S-1:0]     cd;
  logic [S:0]       up_den;
  logic             up_sat;
  logic [LIN_NUM_W-1:0] up_num;
  logic [LIN_NUM_W-1:0] lo_num;
  logic [7:0]       lin_abs;
  logic [CUBE_W-1:0] cube;
  logic [CUBE_W-1:0] cube_r;
  logic [CUBE_PROD_W-1:0] cube_prod;
  logic [6:0]       cube_q;

  // smoothing terms
  logic signed [ST_W-1:0]  old;
  logic signed [SUM_W-1:0] old_ext;
  logic signed [SUM_W-1:0] tgt_ext;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        sum_mag;
  logic [MAG_W-1:0]        sum_mag_r;
  logic [SM_PROD_W-1:0]    sm_prod;
  logic [ST_W-2:0]         new_mag;
  logic [6:0]              pos_mag;
  logic signed [ST_W-1:0]  new_val;
  logic signed [POS_W-1:0] pos_val;
  logic [7:0]              quo8;

  // divider request
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  always_comb begin
    raw     = axis ? raw_y : raw_x;
    ce      = {1'b0, center} + {1'b0, dead};
    diff    = {1'b0, raw} - {1'b0, center};
    dist_w  = diff[S] ? (~diff + 1'b1) : diff;
    in_band = dist_w[S-1:0] < dead;
    upper   = {1'b0, raw} >= ce;
    cd      = center - dead;
    lower   = (center >= dead) && (raw <= cd);
    up_sat  = ce >= MAX_CODE;
    up_den  = MAX_CODE - ce;
    up_num  = LIN_NUM_W'(raw - ce[S-1:0]) * LIN_NUM_W'(LIN_FULL);
    lo_num  = LIN_NUM_W'(raw) * LIN_NUM_W'(LIN_FULL);
    lin_abs = lin[7] ? (~lin + 1'b1) : lin;
    cube    = CUBE_W'(sq) * CUBE_W'(mag);

    cube_prod = CUBE_PROD_W'(cube_r[CUBE_W-1:CUBE_PRE]) * CUBE_PROD_W'(CUBE_RCP);
    cube_q    = cube_prod[CUBE_SH +: 7];

    old     = axis ? y_filt : x_filt;
    old_ext = {{3{old[ST_W-1]}}, old};
    tgt_ext = {{(SUM_W - F - 9){tgt[7]}}, tgt, {(F + 1){1'b0}}};
    sum     = (old_ext <<< 1) + old_ext + tgt_ext;
    sum_mag = sum[SUM_W-1] ? (~sum + 1'b1) : sum;

    sm_prod = SM_PROD_W'(sum_mag_r) * SM_PROD_W'(RCP5);
    new_mag = sm_prod[RCP5_SH +: ST_W-1];
    pos_mag = sm_prod[RCP5_SH+F +: 7];
    new_val = sneg ? -$signed({1'b0, new_mag}) : $signed({1'b0, new_mag});
    pos_val = sneg ? -$signed({1'b0, pos_mag}) : $signed({1'b0, pos_mag});
    quo8    = div_quo[7:0];
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      ST_SHAPE: begin
        if (!in_band) begin
          if (upper && !up_sat) begin
            div_start = 1'b1;
            div_num   = NUM_W'(up_num);
            div_den   = DEN_W'(up_den[S-1:0]);
          end else if (!upper && lower && (cd != '0)) begin
            div_start = 1'b1;
            div_num   = NUM_W'(lo_num);
            div_den   = DEN_W'(cd);
          end
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      axis   <= 1'b0;
      x_filt <= '0;
      y_filt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            raw_x <= x_in;
            raw_y <= y_in;
            axis  <= 1'b0;
            state <= ST_SHAPE;
          end
        end
        ST_SHAPE: begin
          if (in_band) begin
            lin   <= '0;
            state <= ST_MAG;
          end else if (upper) begin
            lin_low <= 1'b0;
            if (up_sat) begin
              lin   <= 8'(LIN_FULL);
              state <= ST_MAG;
            end else begin
              state <= ST_LINDIV;
            end
          end else if (lower) begin
            lin_low <= 1'b1;
            if (cd == '0) begin
              lin   <= -8'(LIN_FULL);
              state <= ST_MAG;
            end else begin
              state <= ST_LINDIV;
            end
          end else begin
            lin   <= '0;
            state <= ST_MAG;
          end
        end
        ST_LINDIV: begin
          if (div_done) begin
            lin   <= lin_low ? (quo8 - 8'(LIN_FULL)) : quo8;
            state <= ST_MAG;
          end
        end
        ST_MAG: begin
          mag   <= lin_abs[6:0];
          neg   <= lin[7];
          sq    <= SQ_W'(lin_abs[6:0]) * SQ_W'(lin_abs[6:0]);
          state <= ST_CUBE;
        end
        ST_CUBE: begin
          cube_r <= cube;
          state  <= ST_CUBEDIV;
        end
        ST_CUBEDIV: begin
          tgt   <= neg ? (~{1'b0, cube_q} + 1'b1) : {1'b0, cube_q};
          state <= ST_SMOOTH;
        end
        ST_SMOOTH: begin
          sneg      <= sum[SUM_W-1];
          sum_mag_r <= sum_mag[MAG_W-1:0];
          state     <= ST_SMDIV;
        end
        ST_SMDIV: begin
          if (axis) begin
            y_filt <= new_val;
            y_pos  <= pos_val;
            state  <= ST_DONE;
          end else begin
            x_filt <= new_val;
            x_pos  <= pos_val;
            axis   <= 1'b1;
            state  <= ST_SHAPE;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  jdes_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule

@@ rtl/joystick_deadzone_expo_smoother.sv @@
// ----------------------------------------------------------------------------
// joystick_deadzone_expo_smoother
// Two-axis joystick deadzone, cubic expo curve and exponential smoother.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_axis    in         x_sample, y_sample (one raw pair per request)
//  m_axis    out        x_pos, y_pos (one smoothed pair per request)
//  cfg       in         center_level (index 0), dead_width (index 1)
//
//  A request runs each axis through six steps, with a pass on the one
//  shared divider when its sample lies outside the dead band and needs the
//  linear map. An accept state and a hand-over state frame the two axes.
//  Synchronous reset clears the smoother state and loads the register defaults.
//  A finished pair waits in the output register, and the next request is
//  taken once the sequencer has handed its pair over.
// ----------------------------------------------------------------------------
module joystick_deadzone_expo_smoother import jdes_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // x_sample, y_sample, zero padding
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // x_pos, y_pos
  output logic [2*POS_W-1:0]     m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SAMPLE_BITS-1:0] cfg_wdata
);

  localparam int S = SAMPLE_BITS;

  logic [S-1:0] center;
  logic [S-1:0] dead;

  logic                    seq_ready;
  logic                    res_valid;
  logic                    res_take;
  logic signed [POS_W-1:0] seq_x;
  logic signed [POS_W-1:0] seq_y;
  logic [POS_W-1:0]        x_pos;
  logic [POS_W-1:0]        y_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= {1'b1, {(S-1){1'b0}}};
      dead   <= S'(DEAD_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER: center <= cfg_wdata;
        REG_DEAD:   dead   <= {1'b0, cfg_wdata[S-2:0]};
        default:    center <= center;
      endcase
    end
  end

  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      x_pos <= seq_x;
      y_pos <= seq_y;
    end
  end

  assign m_axis_tdata  = {y_pos, x_pos};
  assign s_axis_tready = seq_ready;

  jdes_seq #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .center    (center),
    .dead      (dead),
    .in_valid  (s_axis_tvalid),
    .in_ready  (seq_ready),
    .x_in      (s_axis_tdata[S-1:0]),
    .y_in      (s_axis_tdata[2*S-1:S]),
    .res_valid (res_valid),
    .res_take  (res_take),
    .x_pos     (seq_x),
    .y_pos     (seq_y)
  );

endmodule
